// ----- rtl/core/uvs_pkg.sv -----
// Shared widths, codes, state type and sine table math for the UV sphere strip generator.
`default_nettype none

package uvs_pkg;

	localparam int unsigned PHASE_W     = 16;
	localparam int unsigned RADIUS_W    = 16;
	localparam int unsigned SEG_W       = 11;
	localparam int unsigned POS_W       = 17;
	localparam int unsigned TEX_W       = 17;
	localparam int unsigned SINE_W      = 17;
	localparam int unsigned S_TDATA_W   = 8;
	localparam int unsigned M_TDATA_W   = 88;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET     = 16'd256;
	localparam logic [SEG_W-1:0]    SEGMENTS_RESET   = 11'd32;
	localparam logic [PHASE_W-1:0]  PHASE_STEP_RESET = 16'd2048;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'd16384;
	localparam int unsigned        TEX_LIMIT    = 65536;
	localparam int unsigned        POS_LIMIT    = 65535;
	localparam int unsigned        FRAC_SHIFT   = 15;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RADIUS     = 2'd0,
		REG_SEGMENTS   = 2'd1,
		REG_PHASE_STEP = 2'd2
	} uvs_cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_RD_LAT,
		ST_RD_LON,
		ST_NORM,
		ST_SCALE
	} uvs_state_t;

	// sine of a Q30 angle in the first quadrant, Taylor series to x^11, Q.15 result
	function automatic logic signed [SINE_W-1:0] quarter_sine(input longint x);
		longint x2;
		longint t;
		longint s;
		x2 = (x * x) >>> 30;
		t  = ONE_Q30 - x2 / 110;
		t  = ONE_Q30 - ((x2 * t) >>> 30) / 72;
		t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
		t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
		t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
		s  = (x * t) >>> 30;
		return SINE_W'((s + 64'sd16384) >>> 15);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/uv_sphere_strip_vertex_generator.sv -----
// UV sphere triangle strip vertex generator: one vertex per accepted item, none while the segment count gives no ring.
// ANGLE, RD_LAT, RD_LON and NORM follow an accepted item; SCALE loads the output register
// once free. Items are taken one at a time, set by the two passes through the dual-read sine
// table (latitude, then longitude) and the dependent products on two shared multipliers.
// Reset (asynchronous, active low): sweep back to the first vertex, registers to defaults.
`default_nettype none

module uv_sphere_strip_vertex_generator #(
	parameter int MAX_SEGMENTS     = 1024,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [uvs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [uvs_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input items
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [uvs_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [0] restart, rest zero
	// result items
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [16:0] pos_x, [33:17] pos_y, [50:34] pos_z, [67:51] tex_u, [84:68] tex_v, rest zero
	output logic [uvs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	output logic                               m_axis_tlast   // last vertex of the strip
);
	import uvs_pkg::*;

	// widest even segment count the sweep can see
	localparam int SEG_CAP  = (MAX_SEGMENTS > (2 ** SEG_W - 1)) ? (2 ** SEG_W - 1) : MAX_SEGMENTS;
	localparam int SEGS_MAX = SEG_CAP - (SEG_CAP % 2);
	localparam int COL_W    = $clog2(SEGS_MAX + 1);
	localparam int RING_W   = $clog2(SEGS_MAX / 2);
	localparam int ROW_W    = RING_W + 1;
	localparam int PROW_W   = ROW_W + PHASE_W;
	localparam int TV_W     = PROW_W + 1;
	localparam int PCOL_W   = COL_W + PHASE_W;
	localparam int PAD_W    = M_TDATA_W - 3 * POS_W - 2 * TEX_W;

	// configuration registers
	logic [RADIUS_W-1:0] radius_q;
	logic [SEG_W-1:0]    segments_q;
	logic [PHASE_W-1:0]  phase_step_q;

	// sweep state
	logic [RING_W-1:0]   ring_q;
	logic [COL_W-1:0]    col_q;
	logic                lower_q;

	// vertex being worked on
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    vcol_q;
	logic                fin_q;
	logic [PHASE_W-1:0]  lat_q;
	logic [PHASE_W-1:0]  lon_q;
	logic [TEX_W-1:0]    tex_u_q;
	logic [TEX_W-1:0]    tex_v_q;
	logic signed [SINE_W-1:0] cos_lat_q;
	logic signed [POS_W-1:0]  y_q;
	logic signed [POS_W-1:0]  xn_q;
	logic signed [POS_W-1:0]  zn_q;

	// output register
	logic                     out_valid_q;
	logic signed [POS_W-1:0]  out_x_q;
	logic signed [POS_W-1:0]  out_y_q;
	logic signed [POS_W-1:0]  out_z_q;
	logic [TEX_W-1:0]         out_u_q;
	logic [TEX_W-1:0]         out_v_q;
	logic                     out_last_q;

	uvs_state_t state_q;
	uvs_state_t state_d;

	logic s_acc;
	logic out_free;
	logic out_load;
	logic busy_load;

	// ---------------------------------------------------------------------------------------
	// Configuration: taken at any edge with the write enable high; unknown indexes drop
	// ---------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= RADIUS_RESET;
			segments_q   <= SEGMENTS_RESET;
			phase_step_q <= PHASE_STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS:     radius_q     <= cfg_data[RADIUS_W-1:0];
				REG_SEGMENTS:   segments_q   <= cfg_data[SEG_W-1:0];
				REG_PHASE_STEP: phase_step_q <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------------------------
	// Sweep bookkeeping: clamp to the supported count, force it even, rings are half of it
	// ---------------------------------------------------------------------------------------
	logic [SEG_W-1:0]   segs_clip;
	logic [SEG_W-1:0]   segs_eff;
	logic [SEG_W-2:0]   rings;
	logic               no_rings;
	logic               wrap;
	logic [RING_W-1:0]  cur_ring;
	logic [COL_W-1:0]   cur_col;
	logic               cur_lower;
	logic [COL_W:0]     col_inc;
	logic [RING_W:0]    ring_inc;
	logic               col_ovf;
	logic               ring_ovf;
	logic               fin;
	logic [ROW_W-1:0]   row;

	assign segs_clip = (segments_q > SEG_W'(SEG_CAP)) ? SEG_W'(SEG_CAP) : segments_q;
	assign segs_eff  = {segs_clip[SEG_W-1:1], 1'b0};
	assign rings     = segs_eff[SEG_W-1:1];
	assign no_rings  = (rings == '0);

	// restart on request, or when a register change left the indexes out of range
	assign wrap = s_axis_tdata[0]
		|| ((SEG_W-1)'(ring_q) >= rings)
		|| (SEG_W'(col_q) > segs_eff);

	assign cur_ring  = wrap ? '0 : ring_q;
	assign cur_col   = wrap ? '0 : col_q;
	assign cur_lower = wrap ? 1'b0 : lower_q;

	assign col_inc  = {1'b0, cur_col} + 1'b1;
	assign ring_inc = {1'b0, cur_ring} + 1'b1;
	assign col_ovf  = (SEG_W+1)'(col_inc) > (SEG_W+1)'(segs_eff);
	assign ring_ovf = SEG_W'(ring_inc) >= SEG_W'(rings);

	assign fin = cur_lower
		&& (SEG_W'(cur_col) == segs_eff)
		&& ((SEG_W-1)'(cur_ring) == (rings - 1'b1));

	// upper vertex sits one ring further along
	assign row = {1'b0, cur_ring} + ROW_W'(!cur_lower);

	assign s_acc     = s_axis_tvalid && s_axis_tready;
	assign busy_load = s_acc && !no_rings;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q  <= '0;
			col_q   <= '0;
			lower_q <= 1'b0;
		end else if (busy_load) begin
			if (!cur_lower) begin
				lower_q <= 1'b1;
				ring_q  <= cur_ring;
				col_q   <= cur_col;
			end else begin
				lower_q <= 1'b0;
				if (col_ovf) begin
					col_q  <= '0;
					ring_q <= ring_ovf ? '0 : ring_inc[RING_W-1:0];
				end else begin
					col_q  <= col_inc[COL_W-1:0];
					ring_q <= cur_ring;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_load) begin
			row_q  <= row;
			vcol_q <= cur_col;
			fin_q  <= fin;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Angles and texture coordinates
	// ---------------------------------------------------------------------------------------
	logic [PROW_W-1:0] prod_row;
	logic [PCOL_W-1:0] prod_col;
	logic [TV_W-1:0]   tex_v_raw;

	assign prod_row  = PROW_W'(row_q) * PROW_W'(phase_step_q);
	assign prod_col  = PCOL_W'(vcol_q) * PCOL_W'(phase_step_q);
	assign tex_v_raw = {prod_row, 1'b0};

	always_ff @(posedge clk) begin
		if (state_q == ST_ANGLE) begin
			lat_q   <= prod_row[PHASE_W-1:0] - QUARTER_TURN;
			lon_q   <= prod_col[PHASE_W-1:0];
			tex_u_q <= (prod_col > PCOL_W'(TEX_LIMIT)) ? TEX_W'(TEX_LIMIT)
				: prod_col[TEX_W-1:0];
			tex_v_q <= (tex_v_raw > TV_W'(TEX_LIMIT)) ? TEX_W'(TEX_LIMIT)
				: tex_v_raw[TEX_W-1:0];
		end
	end

	// ---------------------------------------------------------------------------------------
	// Sine table: port a reads cosine (phase plus a quarter turn), port b reads sine
	// ---------------------------------------------------------------------------------------
	logic [PHASE_W-1:0]       rom_phase;
	logic signed [SINE_W-1:0] rom_cos;
	logic signed [SINE_W-1:0] rom_sin;

	assign rom_phase = (state_q == ST_RD_LAT) ? lat_q : lon_q;

	uvs_sine_rom #(
		.DEPTH(SINE_TABLE_DEPTH)
	) u_rom (
		.clk    (clk),
		.phase_a(rom_phase + QUARTER_TURN),
		.phase_b(rom_phase),
		.sin_a  (rom_cos),
		.sin_b  (rom_sin)
	);

	// ---------------------------------------------------------------------------------------
	// Two shared multipliers
	//   RD_LON: radius * sin lat                (latitude data just arrived)
	//   NORM:   cos lat * cos lon, cos lat * sin lon
	//   SCALE:  radius * x normal, radius * z normal
	// ---------------------------------------------------------------------------------------
	logic signed [SINE_W-1:0] m0_a;
	logic signed [SINE_W-1:0] m0_b;
	logic signed [SINE_W-1:0] m1_a;
	logic signed [SINE_W-1:0] m1_b;
	logic signed [POS_W-1:0]  m0_p;
	logic signed [POS_W-1:0]  m1_p;
	logic signed [SINE_W-1:0] radius_s;

	assign radius_s = $signed({1'b0, radius_q});

	always_comb begin
		m0_a = radius_s;
		m0_b = SINE_W'(xn_q);
		m1_a = radius_s;
		m1_b = SINE_W'(zn_q);
		case (state_q)
			ST_RD_LON: begin
				m0_b = rom_sin;
			end
			ST_NORM: begin
				m0_a = cos_lat_q;
				m0_b = rom_cos;
				m1_a = cos_lat_q;
				m1_b = rom_sin;
			end
			default: ;
		endcase
	end

	uvs_mul_round u_mul0 (
		.a(m0_a),
		.b(m0_b),
		.p(m0_p)
	);

	uvs_mul_round u_mul1 (
		.a(m1_a),
		.b(m1_b),
		.p(m1_p)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_LON) begin
			cos_lat_q <= rom_cos;
			y_q       <= m0_p;
		end
		if (state_q == ST_NORM) begin
			xn_q <= m0_p;
			zn_q <= m1_p;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------------------------
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (busy_load) state_d = ST_ANGLE;
			ST_ANGLE:  state_d = ST_RD_LAT;
			ST_RD_LAT: state_d = ST_RD_LON;
			ST_RD_LON: state_d = ST_NORM;
			ST_NORM:   state_d = ST_SCALE;
			ST_SCALE:  if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_SCALE: out_load      = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Output register: hold the item until the master side takes it
	// ---------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q    <= m0_p;
			out_y_q    <= y_q;
			out_z_q    <= m1_p;
			out_u_q    <= tex_u_q;
			out_v_q    <= tex_v_q;
			out_last_q <= fin_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {PAD_W'(0), out_v_q, out_u_q, out_z_q, out_y_q, out_x_q};

endmodule

`default_nettype wire

// ----- rtl/core/uvs_mul_round.sv -----
// Signed Q.15 multiply, rounded half away from zero and clamped in magnitude.
`default_nettype none

module uvs_mul_round (
	input  logic signed [uvs_pkg::SINE_W-1:0] a,
	input  logic signed [uvs_pkg::SINE_W-1:0] b,
	output logic signed [uvs_pkg::POS_W-1:0]  p
);
	import uvs_pkg::*;

	localparam int unsigned PROD_W = 2 * SINE_W;
	localparam int unsigned MAG_W  = POS_W - 1;

	logic                    neg;
	logic [SINE_W-1:0]       mag_a;
	logic [SINE_W-1:0]       mag_b;
	logic [PROD_W-1:0]       prod;
	logic [PROD_W-1:0]       rnd;
	logic [MAG_W-1:0]        mag_p;

	assign neg   = a[SINE_W-1] ^ b[SINE_W-1];
	assign mag_a = a[SINE_W-1] ? SINE_W'(~a + 1'b1) : SINE_W'(a);
	assign mag_b = b[SINE_W-1] ? SINE_W'(~b + 1'b1) : SINE_W'(b);
	assign prod  = PROD_W'(mag_a) * PROD_W'(mag_b);
	assign rnd   = (prod + PROD_W'(1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
	assign mag_p = (rnd > PROD_W'(POS_LIMIT)) ? MAG_W'(POS_LIMIT) : rnd[MAG_W-1:0];
	assign p     = neg ? -$signed({1'b0, mag_p}) : $signed({1'b0, mag_p});

endmodule

`default_nettype wire

// ----- rtl/core/uvs_sine_rom.sv -----
// Dual-read sine table with registered outputs, contents built at elaboration.
`default_nettype none

module uvs_sine_rom #(
	parameter int DEPTH = 1024
) (
	input  logic                              clk,
	input  logic [uvs_pkg::PHASE_W-1:0]       phase_a,
	input  logic [uvs_pkg::PHASE_W-1:0]       phase_b,
	output logic signed [uvs_pkg::SINE_W-1:0] sin_a,
	output logic signed [uvs_pkg::SINE_W-1:0] sin_b
);
	import uvs_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int PW = PHASE_W + IW;

	logic signed [SINE_W-1:0] rom_w [DEPTH];
	logic [PW-1:0]            prod_a;
	logic [PW-1:0]            prod_b;
	logic [IW-1:0]            idx_a;
	logic [IW-1:0]            idx_b;

	for (genvar k = 0; k < DEPTH; k++) begin : g_entry
		localparam longint QUAD = (4 * k) / DEPTH;
		localparam longint REM  = (4 * k) % DEPTH;
		localparam longint ARG  = (QUAD % 2 == 1) ? (DEPTH - REM) : REM;
		localparam longint XQ30 = (ARG * HALF_PI_Q30) / DEPTH;
		localparam logic signed [SINE_W-1:0] VAL = quarter_sine(XQ30);
		assign rom_w[k] = (QUAD >= 2) ? -VAL : VAL;
	end

	// phase to entry: (phase * DEPTH) >> 16, always below DEPTH
	assign prod_a = PW'(phase_a) * PW'(DEPTH);
	assign prod_b = PW'(phase_b) * PW'(DEPTH);
	assign idx_a  = prod_a[PW-1:PHASE_W];
	assign idx_b  = prod_b[PW-1:PHASE_W];

	always_ff @(posedge clk) begin
		sin_a <= rom_w[idx_a];
		sin_b <= rom_w[idx_b];
	end

endmodule

`default_nettype wire

// ----- rtl/core/uvs_checker.sv -----
// Port-level checks for the UV sphere strip generator, bound to the top level.
`default_nettype none

module uvs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [uvs_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tlast
);
	import uvs_pkg::*;

	logic s_acc;

	assign s_acc = s_axis_tvalid && s_axis_tready;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result item changed while stalled");

	// a fresh result follows the compute sequence, with no item taken meanwhile
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			!$past(s_acc, 1) && !$past(s_acc, 2) && !$past(s_acc, 3)
			&& !$past(s_acc, 4) && !$past(s_acc, 5))
		else $error("result appeared too soon after an accepted item");

	// positions stay within the saturation limit, texture coordinates within one
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[16:0] != 17'h10000) && (m_axis_tdata[33:17] != 17'h10000)
			&& (m_axis_tdata[50:34] != 17'h10000)
			&& (m_axis_tdata[67:51] <= 17'h10000) && (m_axis_tdata[84:68] <= 17'h10000))
		else $error("result field out of range");

endmodule

bind uv_sphere_strip_vertex_generator uvs_checker u_uvs_checker (.*);

`default_nettype wire
